/* hdl/element_quadrature_matrix_macros.svh */
// Assertion macros used by the checker in eqm_checker.sv.
`ifndef ELEMENT_QUADRATURE_MATRIX_MACROS_SVH
`define ELEMENT_QUADRATURE_MATRIX_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define EQM_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("element_quadrature_matrix: check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define EQM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("element_quadrature_matrix: check failed");

`endif

/* hdl/eqm_pkg.sv */
package eqm_pkg;

  localparam int MAX_NODES  = 8;
  localparam int MAX_POINTS = 16;
  localparam int AXES       = 3;
  localparam int FRAC_BITS  = 24;

  localparam int NODE_W   = 3;
  localparam int POINT_W  = 4;
  localparam int AXIS_W   = 2;
  localparam int VAL_W    = 32;
  localparam int ACC_W    = 64;
  localparam int NN_W     = 4;
  localparam int NP_W     = 5;

  localparam int BV_DEPTH   = MAX_POINTS * MAX_NODES;
  localparam int GRAD_DEPTH = AXES * MAX_POINTS * MAX_NODES;

  // Opcodes of the input stream
  localparam logic [2:0] OP_VALUE   = 3'd0;
  localparam logic [2:0] OP_GRAD    = 3'd1;
  localparam logic [2:0] OP_WEIGHT  = 3'd2;
  localparam logic [2:0] OP_DET     = 3'd3;
  localparam logic [2:0] OP_COMPUTE = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] CFG_MODE   = 2'd0;
  localparam logic [1:0] CFG_NODES  = 2'd1;
  localparam logic [1:0] CFG_POINTS = 2'd2;

  localparam logic [1:0] MODE_MASS = 2'd0;
  localparam logic [1:0] AXIS_NONE = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } seq_state_t;

  // One quadrature slot travelling down the MAC pipeline
  typedef struct packed {
    logic              valid;
    logic              first;
    logic              last_pt;
    logic              zero;
    logic              last_entry;
    logic [NODE_W-1:0] row;
    logic [NODE_W-1:0] col;
  } slot_t;

  function automatic logic [VAL_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic [VAL_W-1:0] res;
    if (v > 64'sd2147483647) begin
      res = 32'h7fff_ffff;
    end else if (v < -64'sd2147483648) begin
      res = 32'h8000_0000;
    end else begin
      res = v[VAL_W-1:0];
    end
    return res;
  endfunction

endpackage

/* hdl/eqm_ram.sv */
module eqm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wa,
  input  logic [WIDTH-1:0]         wd,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] ra,
  output logic [WIDTH-1:0]         rd
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  // Registered read, held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rd <= mem[ra];
    end
  end

endmodule

/* hdl/eqm_seq.sv */
module eqm_seq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       en,
  input  logic                       mac_busy,
  input  logic [eqm_pkg::NN_W-1:0]   nn,
  input  logic [eqm_pkg::NP_W-1:0]   np,
  output logic                       idle,
  output logic [eqm_pkg::NODE_W-1:0] cur_row,
  output logic [eqm_pkg::NODE_W-1:0] cur_col,
  output logic [eqm_pkg::POINT_W-1:0] cur_pt,
  output eqm_pkg::slot_t             slot
);

  eqm_pkg::seq_state_t state_r, state_nxt;
  logic [eqm_pkg::NODE_W-1:0]  row_r, row_nxt, col_r, col_nxt;
  logic [eqm_pkg::POINT_W-1:0] pt_r, pt_nxt;
  eqm_pkg::slot_t              slot_r, slot_nxt;
  logic last_pt, last_col, last_row, zero_pts;

  assign zero_pts = (np == '0);
  assign last_pt  = zero_pts || ({1'b0, pt_r} == np - 5'd1);
  assign last_col = ({1'b0, col_r} == nn - 4'd1);
  assign last_row = ({1'b0, row_r} == nn - 4'd1);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      eqm_pkg::ST_IDLE: begin
        if (start && nn != '0) state_nxt = eqm_pkg::ST_RUN;
      end
      eqm_pkg::ST_RUN: begin
        if (en && last_pt && last_col && last_row) state_nxt = eqm_pkg::ST_DRAIN;
      end
      eqm_pkg::ST_DRAIN: begin
        if (!mac_busy && !slot_r.valid) state_nxt = eqm_pkg::ST_IDLE;
      end
      default: state_nxt = eqm_pkg::ST_IDLE;
    endcase
  end

  // Counters and issued slot
  always_comb begin
    row_nxt  = row_r;
    col_nxt  = col_r;
    pt_nxt   = pt_r;
    slot_nxt = slot_r;
    idle     = 1'b0;
    case (state_r)
      eqm_pkg::ST_IDLE: begin
        idle = 1'b1;
        row_nxt = '0;
        col_nxt = '0;
        pt_nxt  = '0;
        if (en) slot_nxt.valid = 1'b0;
      end
      eqm_pkg::ST_RUN: begin
        if (en) begin
          slot_nxt.valid      = 1'b1;
          slot_nxt.first      = (pt_r == '0);
          slot_nxt.last_pt    = last_pt;
          slot_nxt.zero       = zero_pts;
          slot_nxt.last_entry = last_pt && last_col && last_row;
          slot_nxt.row        = row_r;
          slot_nxt.col        = col_r;
          if (last_pt) begin
            pt_nxt = '0;
            if (last_col) begin
              col_nxt = '0;
              row_nxt = row_r + 3'd1;
            end else begin
              col_nxt = col_r + 3'd1;
            end
          end else begin
            pt_nxt = pt_r + 4'd1;
          end
        end
      end
      eqm_pkg::ST_DRAIN: begin
        if (en) slot_nxt.valid = 1'b0;
      end
      default: begin
        slot_nxt.valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= eqm_pkg::ST_IDLE;
      slot_r  <= '0;
      row_r   <= '0;
      col_r   <= '0;
      pt_r    <= '0;
    end else begin
      state_r <= state_nxt;
      slot_r  <= slot_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      pt_r    <= pt_nxt;
    end
  end

  assign cur_row = row_r;
  assign cur_col = col_r;
  assign cur_pt  = pt_r;
  assign slot    = slot_r;

endmodule

/* hdl/eqm_mac.sv */
module eqm_mac (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  eqm_pkg::slot_t            slot,
  input  logic [eqm_pkg::VAL_W-1:0] left_val,
  input  logic [eqm_pkg::VAL_W-1:0] col_val,
  input  logic [eqm_pkg::VAL_W-1:0] det_val,
  input  logic [eqm_pkg::VAL_W-1:0] w_val,
  input  logic                      out_ready,
  output logic                      busy,
  output logic                      out_valid,
  output logic [eqm_pkg::NODE_W-1:0] out_row,
  output logic [eqm_pkg::NODE_W-1:0] out_col,
  output logic [eqm_pkg::VAL_W-1:0] out_entry,
  output logic                      out_last
);

  eqm_pkg::slot_t st2_r, st3_r, st4_r;
  logic signed [eqm_pkg::ACC_W-1:0] m1_r, m1_nxt, m2_r, m2_nxt, m3_r, m3_nxt;
  logic signed [eqm_pkg::ACC_W-1:0] acc_r, acc_nxt, term;
  logic [eqm_pkg::VAL_W-1:0] det2_r, w2_r, w3_r, t1, t2;
  logic out_valid_r;
  logic [eqm_pkg::NODE_W-1:0] out_row_r, out_col_r;
  logic [eqm_pkg::VAL_W-1:0]  out_entry_r;
  logic out_last_r;

  // Products in the order left*basis, then det, then weight
  always_comb begin
    m1_nxt = $signed(left_val) * $signed(col_val);
    t1     = eqm_pkg::sat32(m1_r >>> eqm_pkg::FRAC_BITS);
    m2_nxt = $signed(t1) * $signed(det2_r);
    t2     = eqm_pkg::sat32(m2_r >>> eqm_pkg::FRAC_BITS);
    m3_nxt = $signed(t2) * $signed(w3_r);
    term   = st4_r.zero ? 64'sd0 : (m3_r >>> eqm_pkg::FRAC_BITS);
    acc_nxt = (st4_r.first ? '0 : acc_r) + term;
  end

  // Advance control of the stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st2_r <= '0;
      st3_r <= '0;
      st4_r <= '0;
      acc_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (en) begin
        st2_r <= slot;
        st3_r <= st2_r;
        st4_r <= st3_r;
        if (st4_r.valid) acc_r <= acc_nxt;
      end
      if (en && st4_r.valid && st4_r.last_pt) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (en) begin
      m1_r   <= m1_nxt;
      det2_r <= det_val;
      w2_r   <= w_val;
      m2_r   <= m2_nxt;
      w3_r   <= w2_r;
      m3_r   <= m3_nxt;
      if (st4_r.valid && st4_r.last_pt) begin
        out_row_r   <= st4_r.row;
        out_col_r   <= st4_r.col;
        out_entry_r <= eqm_pkg::sat32(acc_nxt);
        out_last_r  <= st4_r.last_entry;
      end
    end
  end

  assign busy      = st2_r.valid || st3_r.valid || st4_r.valid;
  assign out_valid = out_valid_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_entry = out_entry_r;
  assign out_last  = out_last_r;

endmodule

/* hdl/element_quadrature_matrix.sv */
// Element quadrature matrix. Loads (opcode in in_tuser: basis value, gradient
// component, weight, determinant) write the on-chip memories, a basis value
// both copies. A compute command streams nodes_in_use squared entries,
// row by row, each the Q8.24 sum over points of left*basis*det*weight; the
// sequencer issues one Gauss point per cycle, unless the output side stalls,
// into a five-stage read and multiply pipeline. Inputs are not taken while a
// compute is running. Memory contents are undefined until loaded.
module element_quadrature_matrix (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [3:0] point_index, [6:4] node_index, [8:7] axis, [40:9] load_value
  input  logic [47:0] in_tdata,
  // [2:0] opcode
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [2:0] row, [5:3] col, [37:6] entry
  output logic [39:0] out_tdata,
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_wdata
);

  logic [1:0] mode_r;
  logic [eqm_pkg::NN_W-1:0] nodes_r, nn;
  logic [eqm_pkg::NP_W-1:0] points_r, np;
  logic accept, en, idle, mac_busy, start;
  logic [eqm_pkg::POINT_W-1:0] ld_pt, cur_pt;
  logic [eqm_pkg::NODE_W-1:0]  ld_nd, cur_row, cur_col, out_row, out_col;
  logic [eqm_pkg::AXIS_W-1:0]  ld_ax, gsel;
  logic [eqm_pkg::VAL_W-1:0]   ld_val, bva_rd, bvb_rd, grad_rd, w_rd, det_rd, left_val;
  logic [eqm_pkg::VAL_W-1:0]   out_entry;
  logic we_bv, we_grad, we_w, we_det;
  eqm_pkg::slot_t slot;

  assign ld_pt  = in_tdata[3:0];
  assign ld_nd  = in_tdata[6:4];
  assign ld_ax  = in_tdata[8:7];
  assign ld_val = in_tdata[40:9];

  assign accept  = in_tvalid && in_tready;
  assign in_tready = idle;
  assign start   = accept && (in_tuser == eqm_pkg::OP_COMPUTE);
  assign we_bv   = accept && (in_tuser == eqm_pkg::OP_VALUE);
  assign we_grad = accept && (in_tuser == eqm_pkg::OP_GRAD) && (ld_ax != eqm_pkg::AXIS_NONE);
  assign we_w    = accept && (in_tuser == eqm_pkg::OP_WEIGHT);
  assign we_det  = accept && (in_tuser == eqm_pkg::OP_DET);

  // Stall the whole pipeline while a result waits
  assign en = !(out_tvalid && !out_tready);

  // Clamp counts to the stored sizes
  assign nn = (nodes_r > eqm_pkg::NN_W'(eqm_pkg::MAX_NODES)) ?
              eqm_pkg::NN_W'(eqm_pkg::MAX_NODES) : nodes_r;
  assign np = (points_r > eqm_pkg::NP_W'(eqm_pkg::MAX_POINTS)) ?
              eqm_pkg::NP_W'(eqm_pkg::MAX_POINTS) : points_r;
  assign gsel = mode_r - 2'd1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 2'd0;
      nodes_r  <= 4'd4;
      points_r <= 5'd4;
    end else if (cfg_we) begin
      case (cfg_index)
        eqm_pkg::CFG_MODE:   mode_r   <= cfg_wdata[1:0];
        eqm_pkg::CFG_NODES:  nodes_r  <= cfg_wdata[3:0];
        eqm_pkg::CFG_POINTS: points_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Basis values, one copy per read address (row and column)
  eqm_ram #(.WIDTH(eqm_pkg::VAL_W), .DEPTH(eqm_pkg::BV_DEPTH)) u_bva (
    .clk(clk), .we(we_bv), .wa({ld_pt, ld_nd}), .wd(ld_val),
    .re(en), .ra({cur_pt, cur_row}), .rd(bva_rd)
  );
  eqm_ram #(.WIDTH(eqm_pkg::VAL_W), .DEPTH(eqm_pkg::BV_DEPTH)) u_bvb (
    .clk(clk), .we(we_bv), .wa({ld_pt, ld_nd}), .wd(ld_val),
    .re(en), .ra({cur_pt, cur_col}), .rd(bvb_rd)
  );
  eqm_ram #(.WIDTH(eqm_pkg::VAL_W), .DEPTH(eqm_pkg::GRAD_DEPTH)) u_grad (
    .clk(clk), .we(we_grad), .wa({ld_ax, ld_pt, ld_nd}), .wd(ld_val),
    .re(en), .ra({gsel, cur_pt, cur_row}), .rd(grad_rd)
  );
  eqm_ram #(.WIDTH(eqm_pkg::VAL_W), .DEPTH(eqm_pkg::MAX_POINTS)) u_w (
    .clk(clk), .we(we_w), .wa(ld_pt), .wd(ld_val),
    .re(en), .ra(cur_pt), .rd(w_rd)
  );
  eqm_ram #(.WIDTH(eqm_pkg::VAL_W), .DEPTH(eqm_pkg::MAX_POINTS)) u_det (
    .clk(clk), .we(we_det), .wa(ld_pt), .wd(ld_val),
    .re(en), .ra(cur_pt), .rd(det_rd)
  );

  assign left_val = (mode_r == eqm_pkg::MODE_MASS) ? bva_rd : grad_rd;

  eqm_seq u_seq (
    .clk(clk), .rst_n(rst_n), .start(start), .en(en), .mac_busy(mac_busy),
    .nn(nn), .np(np), .idle(idle), .cur_row(cur_row), .cur_col(cur_col),
    .cur_pt(cur_pt), .slot(slot)
  );

  eqm_mac u_mac (
    .clk(clk), .rst_n(rst_n), .en(en), .slot(slot),
    .left_val(left_val), .col_val(bvb_rd), .det_val(det_rd), .w_val(w_rd),
    .out_ready(out_tready), .busy(mac_busy), .out_valid(out_tvalid),
    .out_row(out_row), .out_col(out_col), .out_entry(out_entry), .out_last(out_tlast)
  );

  assign out_tdata = {2'b00, out_entry, out_col, out_row};

endmodule

/* hdl/eqm_checker.sv */
`include "element_quadrature_matrix_macros.svh"

module eqm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tlast
);

  // Hold a stalled result
  `EQM_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  // Only the final entry may wait while the input side is open
  `EQM_ASSERT_IMPL(a_idle_only_last, in_tready && out_tvalid, out_tlast)
  // More entries follow a non-final transfer, so input stays closed
  `EQM_ASSERT_NEXT(a_busy_after_mid, out_tvalid && out_tready && !out_tlast, !in_tready)

endmodule

bind element_quadrature_matrix eqm_checker u_eqm_checker (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready), .out_tvalid(out_tvalid),
  .out_tready(out_tready), .out_tdata(out_tdata), .out_tlast(out_tlast)
);
